// ===== rtl/tfst_pkg.sv =====
// Package for the TCP flow state tracker: flow record layout, flag and
// anomaly codes, opcodes and the record update result type.
// No dependencies.
`timescale 1ns / 1ps

package tfst_pkg;

	localparam int FLOW_COUNT = 1024;
	localparam int FLOW_W = $clog2(FLOW_COUNT);
	localparam int CFG_AW = 3;

	// Opcodes of the event channel.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SEG = 2'd1;
	localparam logic [1:0] OP_TERM = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_TO_RESET = 3'd0;
	localparam logic [CFG_AW-1:0] REG_TO_NEW = 3'd1;
	localparam logic [CFG_AW-1:0] REG_TO_EST = 3'd2;
	localparam logic [CFG_AW-1:0] REG_TO_CLOSING = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TO_CLOSED = 3'd4;

	// TCP flags and masks.
	localparam logic [7:0] F_FIN = 8'h01;
	localparam logic [7:0] F_SYN = 8'h02;
	localparam logic [7:0] F_RST = 8'h04;
	localparam logic [7:0] F_ACK = 8'h10;
	localparam logic [7:0] M_ARSF = 8'h17;
	localparam logic [7:0] M_SFR = 8'h07;
	localparam logic [7:0] M_SA = 8'h12;
	localparam logic [7:0] M_ALL = 8'h3F;
	localparam logic [7:0] XMAS = 8'h29;

	// Anomaly bits.
	localparam logic [6:0] A_NONE = 7'h00;
	localparam logic [6:0] A_SETUP = 7'h01;
	localparam logic [6:0] A_EVIL = 7'h02;
	localparam logic [6:0] A_RSTS = 7'h04;
	localparam logic [6:0] A_TEAR = 7'h08;
	localparam logic [6:0] A_EFLG = 7'h10;
	localparam logic [6:0] A_CLOSE = 7'h20;
	localparam logic [6:0] A_RESET = 7'h40;

	// Connection states.
	localparam logic [2:0] S_NEW = 3'd0;
	localparam logic [2:0] S_EST = 3'd1;
	localparam logic [2:0] S_CLOSING = 3'd2;
	localparam logic [2:0] S_CLOSED = 3'd3;
	localparam logic [2:0] S_RESET = 3'd4;

	typedef struct packed {
		logic [2:0]  st;
		logic        syn_obs;
		logic        syn_acked;
		logic        fin_obs;
		logic        fin_acked;
		logic        fin_probe;
		logic [6:0]  anom;
		logic [31:0] syn_seq;
		logic [31:0] fin_seq;
	} rec_t;

	typedef struct packed {
		logic [15:0] t_reset;
		logic [15:0] t_new;
		logic [15:0] t_est;
		logic [15:0] t_closing;
		logic [15:0] t_closed;
	} tmo_cfg_t;

	typedef struct packed {
		rec_t        c;
		rec_t        r;
		logic        ct_v;
		logic [15:0] ct_t;
		logic        rt_v;
		logic [15:0] rt_t;
		logic [6:0]  agg;
	} upd_t;

	function automatic rec_t to_st(rec_t x, logic [2:0] st, logic [6:0] add);
		rec_t y;
		y = x;
		y.st = st;
		y.anom = x.anom | add;
		return y;
	endfunction

endpackage

// ===== rtl/tfst_evt_if.sv =====
// Event channel interface: valid/ready handshake and one event word.
// Depends on nothing.
`timescale 1ns / 1ps

interface tfst_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [9:0]  flow_index;
	logic        has_opposite;
	logic [9:0]  opposite_index;
	logic [7:0]  tcp_flags;
	logic [31:0] seq_num;
	logic [31:0] ack_num;

	modport source(output valid, opcode, flow_index, has_opposite, opposite_index,
		tcp_flags, seq_num, ack_num, input ready);
	modport sink(input valid, opcode, flow_index, has_opposite, opposite_index,
		tcp_flags, seq_num, ack_num, output ready);
endinterface

// ===== rtl/tfst_res_if.sv =====
// Result channel interface: valid/ready handshake and one result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface tfst_res_if;
	logic        valid;
	logic        ready;
	logic [6:0]  anomalies;
	logic [2:0]  flow_state;
	logic        flow_timeout_valid;
	logic [15:0] flow_timeout_value;
	logic        opp_timeout_valid;
	logic [15:0] opp_timeout_value;
	logic [6:0]  aggregate_anomalies;

	modport source(output valid, anomalies, flow_state, flow_timeout_valid,
		flow_timeout_value, opp_timeout_valid, opp_timeout_value,
		aggregate_anomalies, input ready);
	modport sink(input valid, anomalies, flow_state, flow_timeout_valid,
		flow_timeout_value, opp_timeout_valid, opp_timeout_value,
		aggregate_anomalies, output ready);
endinterface

// ===== rtl/tfst_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on nothing.
`timescale 1ns / 1ps

interface tfst_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [15:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== rtl/tcp_flow_state_tracker.sv =====
// TCP flow state tracker. Event word and table reads are registered on acceptance,
// the result word in the compute state, which waits while a result is still held.
// One write port: flow record, then opposite record, while a next event may be read.
// Reset clears control, the aggregate and the timeout registers to their defaults;
// the flow table is not cleared and each entry must be cleared by opcode 0 first.
// Depends on tfst_pkg, tfst_evt_if, tfst_res_if, tfst_cfg_if and tfst_update.
`timescale 1ns / 1ps

module tcp_flow_state_tracker import tfst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tfst_cfg_if.sink cfg,
	tfst_evt_if.sink evt,
	tfst_res_if.source res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_WR_R = 2'd2;

	logic [1:0]        phase_q;
	tmo_cfg_t          tmo_q;
	logic [6:0]        agg_q;

	rec_t              flow_mem [FLOW_COUNT];
	rec_t              rd_c_s1;
	rec_t              rd_r_s1;

	logic [1:0]        op_s1;
	logic              hop_s1;
	logic              alias_s1;
	logic [7:0]        fl_s1;
	logic [31:0]       seq_s1;
	logic [31:0]       ack_s1;
	logic [FLOW_W-1:0] fi_s1;
	logic [FLOW_W-1:0] oi_s1;
	rec_t              r_wb_q;

	logic              res_valid_q;
	logic [6:0]        res_anom_q;
	logic [2:0]        res_st_q;
	logic              res_ct_v_q;
	logic [15:0]       res_ct_t_q;
	logic              res_rt_v_q;
	logic [15:0]       res_rt_t_q;
	logic [6:0]        res_agg_q;

	upd_t              upd;
	logic              acc;
	logic              out_free;
	logic              calc_go;
	logic              need_r;
	logic              mem_we;
	logic [FLOW_W-1:0] mem_waddr;
	rec_t              mem_wdata;
	logic [FLOW_W-1:0] ra_c;
	logic [FLOW_W-1:0] ra_r;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q.t_reset <= 16'd1;
			tmo_q.t_new <= 16'd120;
			tmo_q.t_est <= 16'd3600;
			tmo_q.t_closing <= 16'd120;
			tmo_q.t_closed <= 16'd10;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_TO_RESET: tmo_q.t_reset <= cfg.data;
				REG_TO_NEW: tmo_q.t_new <= cfg.data;
				REG_TO_EST: tmo_q.t_est <= cfg.data;
				REG_TO_CLOSING: tmo_q.t_closing <= cfg.data;
				REG_TO_CLOSED: tmo_q.t_closed <= cfg.data;
				default: ;
			endcase
		end
	end

	assign evt.ready = (phase_q == ST_IDLE) || (phase_q == ST_WR_R);
	assign acc = evt.valid && evt.ready;
	assign out_free = !res_valid_q || res.ready;
	assign calc_go = (phase_q == ST_CALC) && out_free;
	assign need_r = hop_s1 && !alias_s1 && (op_s1 == OP_SEG || op_s1 == OP_TERM);
	assign ra_c = evt.flow_index[FLOW_W-1:0];
	assign ra_r = evt.opposite_index[FLOW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_IDLE;
		end else begin
			case (phase_q)
				ST_IDLE: begin
					if (acc) phase_q <= ST_CALC;
				end
				ST_CALC: begin
					if (calc_go) phase_q <= need_r ? ST_WR_R : ST_IDLE;
				end
				ST_WR_R: begin
					phase_q <= acc ? ST_CALC : ST_IDLE;
				end
				default: phase_q <= ST_IDLE;
			endcase
		end
	end

	// One write port: the flow record goes back in the compute cycle, the
	// opposite record in the cycle after.
	assign mem_we = calc_go || (phase_q == ST_WR_R);
	assign mem_waddr = calc_go ? fi_s1 : oi_s1;
	assign mem_wdata = calc_go ? upd.c : r_wb_q;

	always_ff @(posedge clk) begin
		if (mem_we) flow_mem[mem_waddr] <= mem_wdata;
	end

	// A read taken together with the opposite write-back sees the new data.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_c_s1 <= (mem_we && mem_waddr == ra_c) ? mem_wdata : flow_mem[ra_c];
			rd_r_s1 <= (mem_we && mem_waddr == ra_r) ? mem_wdata : flow_mem[ra_r];
			op_s1 <= evt.opcode;
			hop_s1 <= evt.has_opposite;
			alias_s1 <= evt.has_opposite && (ra_r == ra_c);
			fl_s1 <= evt.tcp_flags;
			seq_s1 <= evt.seq_num;
			ack_s1 <= evt.ack_num;
			fi_s1 <= ra_c;
			oi_s1 <= ra_r;
		end
	end

	tfst_update u_update (
		.op       (op_s1),
		.hop      (hop_s1),
		.alias_fl (alias_s1),
		.fl       (fl_s1),
		.seq      (seq_s1),
		.ack      (ack_s1),
		.rd_c     (rd_c_s1),
		.rd_r     (rd_r_s1),
		.agg      (agg_q),
		.tmo      (tmo_q),
		.upd      (upd)
	);

	always_ff @(posedge clk) begin
		if (calc_go) begin
			r_wb_q <= upd.r;
			res_anom_q <= upd.c.anom;
			res_st_q <= upd.c.st;
			res_ct_v_q <= upd.ct_v;
			res_ct_t_q <= upd.ct_t;
			res_rt_v_q <= upd.rt_v;
			res_rt_t_q <= upd.rt_t;
			res_agg_q <= upd.agg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (calc_go) agg_q <= upd.agg;
			if (calc_go) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	assign res.valid = res_valid_q;
	assign res.anomalies = res_anom_q;
	assign res.flow_state = res_st_q;
	assign res.flow_timeout_valid = res_ct_v_q;
	assign res.flow_timeout_value = res_ct_t_q;
	assign res.opp_timeout_valid = res_rt_v_q;
	assign res.opp_timeout_value = res_rt_t_q;
	assign res.aggregate_anomalies = res_agg_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ST_IDLE) |-> !mem_we)
		else $error("flow table written while idle");

	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (phase_q == ST_CALC))
		else $error("accepted word did not enter the compute cycle");

	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(phase_q) == ST_CALC))
		else $error("result word raised outside the compute cycle");

	a_opp_write_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ST_WR_R) |-> (oi_s1 != fi_s1))
		else $error("opposite write-back aimed at the flow's own entry");

endmodule

// ===== rtl/tfst_update.sv =====
// Record update logic: applies one event to a flow record and its opposite.
// Depends on tfst_pkg.
`timescale 1ns / 1ps

module tfst_update import tfst_pkg::*; (
	input  logic [1:0]  op,
	input  logic        hop,
	input  logic        alias_fl,
	input  logic [7:0]  fl,
	input  logic [31:0] seq,
	input  logic [31:0] ack,
	input  rec_t        rd_c,
	input  rec_t        rd_r,
	input  logic [6:0]  agg,
	input  tmo_cfg_t    tmo,
	output upd_t        upd
);

	rec_t        c;
	rec_t        r;
	logic        ct_v;
	logic [15:0] ct_t;
	logic        rt_v;
	logic [15:0] rt_t;
	logic [7:0]  arsf;
	logic [7:0]  fall;
	logic [2:0]  st0;
	logic [6:0]  agg_n;

	// When the flow is its own opposite, both views name one record; in segment and
	// termination events every write to one view is copied to the other right away, and
	// timeouts for the opposite land in the flow's slot as well.
	always_comb begin
		c = rd_c;
		r = alias_fl ? rd_c : rd_r;
		ct_v = 1'b0;
		ct_t = '0;
		rt_v = 1'b0;
		rt_t = '0;
		agg_n = agg;
		arsf = fl & M_ARSF;
		fall = fl & M_ALL;
		st0 = rd_c.st;

		case (op)
			OP_CLEAR: begin
				c = '0;
			end
			OP_SEG: begin
				if (fall == XMAS || fall == 8'h00) begin
					c.anom = c.anom | A_EVIL;
					if (alias_fl) r = c;
				end
				st0 = c.st;
				case (st0)
					S_NEW: begin
						if ((fl & M_SFR) == F_SYN) begin
							c.syn_obs = 1'b1;
							c.syn_seq = seq;
							ct_v = 1'b1;
							ct_t = tmo.t_new;
							if (alias_fl) r = c;
							if ((fl & F_ACK) != 8'h00) begin
								if (hop && ack == r.syn_seq + 32'd1) begin
									r.syn_acked = 1'b1;
									if (alias_fl) c = r;
								end else begin
									c = to_st(c, S_EST, A_SETUP);
									ct_v = 1'b1;
									ct_t = tmo.t_est;
									if (alias_fl) r = c;
									if (hop) begin
										r = to_st(r, S_EST, A_SETUP);
										rt_v = 1'b1;
										rt_t = tmo.t_est;
										if (alias_fl) begin
											c = r;
											ct_v = 1'b1;
											ct_t = tmo.t_est;
										end
									end
								end
							end
						end else if (hop && arsf == F_ACK) begin
							if (ack == r.syn_seq + 32'd1) begin
								r.syn_acked = 1'b1;
								if (alias_fl) c = r;
								if (c.syn_acked) begin
									c = to_st(c, S_EST, A_NONE);
									ct_v = 1'b1;
									ct_t = tmo.t_est;
									if (alias_fl) r = c;
									r = to_st(r, S_EST, A_NONE);
									rt_v = 1'b1;
									rt_t = tmo.t_est;
									if (alias_fl) c = r;
								end
							end else begin
								c = to_st(c, S_EST, A_SETUP);
								ct_v = 1'b1;
								ct_t = tmo.t_est;
								if (alias_fl) r = c;
								r = to_st(r, S_EST, A_SETUP);
								rt_v = 1'b1;
								rt_t = tmo.t_est;
								if (alias_fl) c = r;
							end
						end else if (hop && arsf == (F_RST | F_ACK)) begin
							c = to_st(c, S_RESET, A_RSTS);
							ct_v = 1'b1;
							ct_t = tmo.t_reset;
							if (alias_fl) r = c;
							r = to_st(r, S_RESET, A_NONE);
							rt_v = 1'b1;
							rt_t = tmo.t_reset;
							if (alias_fl) c = r;
						end else if ((fl & F_RST) != 8'h00) begin
							c = to_st(c, S_RESET, A_RSTS | A_SETUP);
							ct_v = 1'b1;
							ct_t = tmo.t_reset;
							if (alias_fl) r = c;
							if (hop) begin
								r = to_st(r, S_RESET, A_SETUP);
								rt_v = 1'b1;
								rt_t = tmo.t_reset;
								if (alias_fl) c = r;
							end else begin
								c.anom = c.anom | A_EVIL;
							end
						end else if (arsf == (F_FIN | F_ACK)) begin
							c.fin_obs = 1'b1;
							c.fin_seq = seq;
							c = to_st(c, S_CLOSING, A_SETUP);
							ct_v = 1'b1;
							ct_t = tmo.t_closing;
							if (alias_fl) r = c;
							if (hop) begin
								r.anom = r.anom | A_SETUP;
								if (alias_fl) c = r;
								if (r.fin_obs && r.fin_seq + 32'd1 == ack) begin
									r.fin_acked = 1'b1;
									if (alias_fl) c = r;
								end
							end else begin
								c.fin_probe = 1'b1;
							end
						end else if (arsf == F_FIN) begin
							c.anom = c.anom | A_EVIL;
							if (alias_fl) r = c;
						end else begin
							c = to_st(c, S_EST, A_SETUP);
							ct_v = 1'b1;
							ct_t = tmo.t_est;
							if (alias_fl) r = c;
							if (hop) begin
								r = to_st(r, S_EST, A_SETUP);
								rt_v = 1'b1;
								rt_t = tmo.t_est;
								if (alias_fl) c = r;
							end
						end
					end
					S_EST: begin
						if ((fl & M_SA) != F_ACK) begin
							c.anom = c.anom | A_EFLG;
							if (alias_fl) r = c;
							if (hop) begin
								r.anom = r.anom | A_EFLG;
								if (alias_fl) c = r;
							end
						end
						if ((fl & F_FIN) != 8'h00) begin
							c.fin_obs = 1'b1;
							c.fin_seq = seq;
							c = to_st(c, S_CLOSING, A_NONE);
							ct_v = 1'b1;
							ct_t = tmo.t_closing;
							if (alias_fl) r = c;
							if ((fl & F_ACK) != 8'h00 && hop && r.fin_obs &&
								ack == r.fin_seq + 32'd1) begin
								r.fin_acked = 1'b1;
								if (alias_fl) c = r;
							end
						end
						if ((fl & F_RST) != 8'h00) begin
							c = to_st(c, S_RESET, A_RSTS | A_TEAR);
							ct_v = 1'b1;
							ct_t = tmo.t_reset;
							if (alias_fl) r = c;
							if (hop) begin
								r = to_st(r, S_RESET, A_TEAR);
								rt_v = 1'b1;
								rt_t = tmo.t_reset;
								if (alias_fl) c = r;
							end
						end
					end
					S_CLOSING: begin
						if ((fl & F_RST) != 8'h00) begin
							c = to_st(c, S_RESET, A_RSTS | A_TEAR);
							ct_v = 1'b1;
							ct_t = tmo.t_reset;
							if (alias_fl) r = c;
							if (hop) begin
								r = to_st(r, S_RESET, A_TEAR);
								rt_v = 1'b1;
								rt_t = tmo.t_reset;
								if (alias_fl) c = r;
							end
						end
						if ((fl & F_ACK) != 8'h00 && hop && r.fin_obs &&
							ack == r.fin_seq + 32'd1) begin
							r.fin_acked = 1'b1;
							if (alias_fl) c = r;
						end
						if (hop && c.fin_obs && c.fin_acked && r.fin_obs && r.fin_acked) begin
							c = to_st(c, S_CLOSED, A_NONE);
							ct_v = 1'b1;
							ct_t = tmo.t_closed;
							if (alias_fl) r = c;
							r = to_st(r, S_CLOSED, A_NONE);
							rt_v = 1'b1;
							rt_t = tmo.t_closed;
							if (alias_fl) c = r;
						end
					end
					S_CLOSED: begin
						c.anom = c.anom | A_CLOSE;
						if (alias_fl) r = c;
						if ((fl & F_RST) != 8'h00) begin
							c = to_st(c, S_RESET, A_RSTS | A_TEAR);
							ct_v = 1'b1;
							ct_t = tmo.t_reset;
							if (alias_fl) r = c;
							if (hop) begin
								r = to_st(r, S_RESET, A_TEAR);
								rt_v = 1'b1;
								rt_t = tmo.t_reset;
								if (alias_fl) c = r;
							end
						end
					end
					default: begin
						c.anom = c.anom | A_RESET;
						if (alias_fl) r = c;
					end
				endcase
			end
			OP_TERM: begin
				if (!hop) begin
					c.anom = c.anom | A_SETUP | A_TEAR;
				end else begin
					if (!(c.syn_obs && r.syn_obs && c.syn_acked && r.syn_acked)) begin
						c.anom = c.anom | A_SETUP;
						if (alias_fl) r = c;
					end
					if (!(c.fin_obs && r.fin_obs && c.fin_acked && r.fin_acked)) begin
						c.anom = c.anom | A_TEAR;
						if (alias_fl) r = c;
					end else begin
						c.fin_probe = 1'b0;
						r.fin_probe = 1'b0;
					end
				end
				if (c.fin_probe) begin
					c.anom = c.anom | A_EVIL;
					if (alias_fl) r = c;
				end
				agg_n = agg | c.anom;
			end
			default: begin
				c = rd_c;
			end
		endcase

		// Both timeout slots name the same flow when it is its own opposite.
		if (alias_fl) begin
			rt_v = ct_v;
			rt_t = ct_t;
		end
	end

	assign upd.c = c;
	assign upd.r = r;
	assign upd.ct_v = ct_v;
	assign upd.ct_t = ct_t;
	assign upd.rt_v = rt_v;
	assign upd.rt_t = rt_t;
	assign upd.agg = agg_n;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for tcp_flow_state_tracker: drives flow events and timeout
// register writes, predicts every result word and compares it field by field.
// Depends on tfst_pkg, the three channel interfaces and the tracker top level.
`timescale 1ns / 1ps

module tb_top import tfst_pkg::*; ();

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd5;
	localparam logic [CFG_AW-1:0] REG_LAST = 3'd7;
	localparam logic [7:0] F_PSH = 8'h08;

	typedef struct packed {
		logic [6:0]  anomalies;
		logic [2:0]  flow_state;
		logic        flow_timeout_valid;
		logic [15:0] flow_timeout_value;
		logic        opp_timeout_valid;
		logic [15:0] opp_timeout_value;
		logic [6:0]  aggregate_anomalies;
	} flow_report_t;

	logic clk;
	logic arst_n;

	tfst_cfg_if cfg_bus();
	tfst_evt_if evt_bus();
	tfst_res_if res_bus();

	tcp_flow_state_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.evt(evt_bus),
		.res(res_bus)
	);

	// Shadow copy of the flow table, the aggregate and the timeout registers.
	rec_t flow_tab[FLOW_COUNT];
	bit written[FLOW_COUNT];
	int live_flows[$];
	tmo_cfg_t tmo;
	logic [6:0] agg_or;
	bit tmr_v[2];
	logic [15:0] tmr_t[2];

	flow_report_t expected_reports[$];
	int n_sent, n_checked, n_fail, n_cfg, n_conv;
	bit tx_idle, rx_idle;
	int rx_hold, rx_wait;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void arm_timer(int s, logic [15:0] v);
		tmr_v[s] = 1'b1;
		tmr_t[s] = v;
	endfunction

	function automatic void move_to(int idx, int s, logic [2:0] st, logic [15:0] v,
			logic [6:0] add);
		flow_tab[idx].st = st;
		arm_timer(s, v);
		flow_tab[idx].anom = flow_tab[idx].anom | add;
	endfunction

	function automatic void tear_reset(int c, int r, bit hr, int rs);
		move_to(c, 0, S_RESET, tmo.t_reset, A_RSTS | A_TEAR);
		if (hr) move_to(r, rs, S_RESET, tmo.t_reset, A_TEAR);
	endfunction

	function automatic void apply_segment(int c, int r, bit hr, int rs, logic [7:0] fl,
			logic [31:0] sq, logic [31:0] ak);
		logic [7:0] arsf;
		bit has_ack;
		bit has_fin;
		bit has_rst;
		arsf = fl & M_ARSF;
		has_ack = (fl & F_ACK) != 8'h00;
		has_fin = (fl & F_FIN) != 8'h00;
		has_rst = (fl & F_RST) != 8'h00;
		// Xmas and null scans are flagged whatever the state.
		if ((fl & M_ALL) == XMAS || (fl & M_ALL) == 8'h00)
			flow_tab[c].anom = flow_tab[c].anom | A_EVIL;
		case (flow_tab[c].st)
			S_NEW: begin
				if ((fl & M_SFR) == F_SYN) begin
					flow_tab[c].syn_obs = 1'b1;
					flow_tab[c].syn_seq = sq;
					arm_timer(0, tmo.t_new);
					if (has_ack) begin
						if (hr && ak == flow_tab[r].syn_seq + 32'd1) begin
							flow_tab[r].syn_acked = 1'b1;
						end else begin
							move_to(c, 0, S_EST, tmo.t_est, A_SETUP);
							if (hr) move_to(r, rs, S_EST, tmo.t_est, A_SETUP);
						end
					end
				end else if (hr && arsf == F_ACK) begin
					if (ak == flow_tab[r].syn_seq + 32'd1) begin
						flow_tab[r].syn_acked = 1'b1;
						if (flow_tab[c].syn_acked) begin
							move_to(c, 0, S_EST, tmo.t_est, A_NONE);
							move_to(r, rs, S_EST, tmo.t_est, A_NONE);
						end
					end else begin
						move_to(c, 0, S_EST, tmo.t_est, A_SETUP);
						move_to(r, rs, S_EST, tmo.t_est, A_SETUP);
					end
				end else if (hr && arsf == (F_RST | F_ACK)) begin
					move_to(c, 0, S_RESET, tmo.t_reset, A_RSTS);
					move_to(r, rs, S_RESET, tmo.t_reset, A_NONE);
				end else if (has_rst) begin
					move_to(c, 0, S_RESET, tmo.t_reset, A_RSTS | A_SETUP);
					if (hr) move_to(r, rs, S_RESET, tmo.t_reset, A_SETUP);
					else flow_tab[c].anom = flow_tab[c].anom | A_EVIL;
				end else if (arsf == (F_FIN | F_ACK)) begin
					flow_tab[c].fin_obs = 1'b1;
					flow_tab[c].fin_seq = sq;
					move_to(c, 0, S_CLOSING, tmo.t_closing, A_SETUP);
					if (hr) begin
						flow_tab[r].anom = flow_tab[r].anom | A_SETUP;
						if (flow_tab[r].fin_obs && flow_tab[r].fin_seq + 32'd1 == ak)
							flow_tab[r].fin_acked = 1'b1;
					end else begin
						// A lone FIN|ACK with no reverse flow looks like a FIN scan.
						flow_tab[c].fin_probe = 1'b1;
					end
				end else if (arsf == F_FIN) begin
					flow_tab[c].anom = flow_tab[c].anom | A_EVIL;
				end else begin
					move_to(c, 0, S_EST, tmo.t_est, A_SETUP);
					if (hr) move_to(r, rs, S_EST, tmo.t_est, A_SETUP);
				end
			end
			S_EST: begin
				if ((fl & M_SA) != F_ACK) begin
					flow_tab[c].anom = flow_tab[c].anom | A_EFLG;
					if (hr) flow_tab[r].anom = flow_tab[r].anom | A_EFLG;
				end
				if (has_fin) begin
					flow_tab[c].fin_obs = 1'b1;
					flow_tab[c].fin_seq = sq;
					move_to(c, 0, S_CLOSING, tmo.t_closing, A_NONE);
					if (has_ack && hr && flow_tab[r].fin_obs &&
							ak == flow_tab[r].fin_seq + 32'd1)
						flow_tab[r].fin_acked = 1'b1;
				end
				if (has_rst) tear_reset(c, r, hr, rs);
			end
			S_CLOSING: begin
				if (has_rst) tear_reset(c, r, hr, rs);
				if (has_ack && hr && flow_tab[r].fin_obs && ak == flow_tab[r].fin_seq + 32'd1)
					flow_tab[r].fin_acked = 1'b1;
				if (hr && flow_tab[c].fin_obs && flow_tab[c].fin_acked &&
						flow_tab[r].fin_obs && flow_tab[r].fin_acked) begin
					move_to(c, 0, S_CLOSED, tmo.t_closed, A_NONE);
					move_to(r, rs, S_CLOSED, tmo.t_closed, A_NONE);
				end
			end
			S_CLOSED: begin
				flow_tab[c].anom = flow_tab[c].anom | A_CLOSE;
				if (has_rst) tear_reset(c, r, hr, rs);
			end
			default: flow_tab[c].anom = flow_tab[c].anom | A_RESET;
		endcase
	endfunction

	function automatic void close_out(int c, int r, bit hr);
		if (!hr) begin
			flow_tab[c].anom = flow_tab[c].anom | A_SETUP | A_TEAR;
		end else begin
			if (!(flow_tab[c].syn_obs && flow_tab[r].syn_obs &&
					flow_tab[c].syn_acked && flow_tab[r].syn_acked))
				flow_tab[c].anom = flow_tab[c].anom | A_SETUP;
			if (!(flow_tab[c].fin_obs && flow_tab[r].fin_obs &&
					flow_tab[c].fin_acked && flow_tab[r].fin_acked)) begin
				flow_tab[c].anom = flow_tab[c].anom | A_TEAR;
			end else begin
				flow_tab[c].fin_probe = 1'b0;
				flow_tab[r].fin_probe = 1'b0;
			end
		end
		if (flow_tab[c].fin_probe) flow_tab[c].anom = flow_tab[c].anom | A_EVIL;
		agg_or = agg_or | flow_tab[c].anom;
	endfunction

	function automatic flow_report_t track_event(logic [1:0] op, int fi, bit hop, int oi,
			logic [7:0] fl, logic [31:0] sq, logic [31:0] ak);
		flow_report_t rep;
		bit self_opp;
		int r;
		int rs;
		self_opp = hop && (oi == fi);
		r = hop ? oi : fi;
		// A flow that is its own opposite shares one timeout slot.
		rs = self_opp ? 0 : 1;
		tmr_v[0] = 1'b0;
		tmr_v[1] = 1'b0;
		tmr_t[0] = 16'd0;
		tmr_t[1] = 16'd0;
		case (op)
			OP_CLEAR: begin
				flow_tab[fi] = '0;
				if (!written[fi]) begin
					written[fi] = 1'b1;
					live_flows.push_back(fi);
				end
			end
			OP_SEG: apply_segment(fi, r, hop, rs, fl, sq, ak);
			OP_TERM: close_out(fi, r, hop);
			default: ;
		endcase
		if (self_opp) begin
			tmr_v[1] = tmr_v[0];
			tmr_t[1] = tmr_t[0];
		end
		rep.anomalies = flow_tab[fi].anom;
		rep.flow_state = flow_tab[fi].st;
		rep.flow_timeout_valid = tmr_v[0];
		rep.flow_timeout_value = tmr_t[0];
		rep.opp_timeout_valid = tmr_v[1];
		rep.opp_timeout_value = tmr_t[1];
		rep.aggregate_anomalies = agg_or;
		return rep;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	function automatic int pick_live();
		return live_flows[$urandom_range(0, live_flows.size() - 1)];
	endfunction

	// The valid of the event channel is left high after a word so that a
	// back-to-back word never lowers and raises it in one time step.
	task automatic send_event(input logic [1:0] op, input int fi, input bit hop, input int oi,
			input logic [7:0] fl, input logic [31:0] sq, input logic [31:0] ak);
		int gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_bus.valid <= 1'b1;
		evt_bus.opcode <= op;
		evt_bus.flow_index <= fi[9:0];
		evt_bus.has_opposite <= hop;
		evt_bus.opposite_index <= oi[9:0];
		evt_bus.tcp_flags <= fl;
		evt_bus.seq_num <= sq;
		evt_bus.ack_num <= ak;
		@(posedge clk);
		while (evt_bus.ready !== 1'b1) @(posedge clk);
		expected_reports.push_back(track_event(op, fi, hop, oi, fl, sq, ak));
		n_sent++;
	endtask

	task automatic settle();
		evt_bus.valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.addr <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (cfg_bus.ready !== 1'b1) @(posedge clk);
		case (idx)
			REG_TO_RESET: tmo.t_reset = val;
			REG_TO_NEW: tmo.t_new = val;
			REG_TO_EST: tmo.t_est = val;
			REG_TO_CLOSING: tmo.t_closing = val;
			REG_TO_CLOSED: tmo.t_closed = val;
			default: ;
		endcase
		n_cfg++;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_random_timeouts();
		int pick;
		for (int k = REG_TO_RESET; k <= REG_TO_CLOSED; k++) begin
			pick = $urandom_range(0, 3);
			write_reg(CFG_AW'(k), pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : 16'($urandom));
		end
		if ($urandom_range(0, 1) == 0)
			write_reg(CFG_AW'($urandom_range(REG_UNUSED, REG_LAST)), 16'($urandom));
	endtask

	// One segment of a conversation, sometimes lost, with damaged flags or a
	// damaged acknowledgement, or sent without its reverse flow.
	task automatic conv_seg(input int a, input int b, input bit dir, input logic [7:0] fl,
			input logic [31:0] sq, input logic [31:0] ak);
		int src;
		int dst;
		bit hop;
		logic [7:0] f;
		logic [31:0] k;
		src = dir ? b : a;
		dst = dir ? a : b;
		f = fl;
		k = ak;
		if ($urandom_range(0, 11) == 0) return;
		if ($urandom_range(0, 9) == 0) f = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 11) == 0) k = ak ^ (32'd1 << $urandom_range(0, 31));
		hop = $urandom_range(0, 19) != 0;
		send_event(OP_SEG, src, hop, hop ? dst : $urandom_range(0, 1023), f, sq, k);
	endtask

	task automatic run_conversation();
		int a;
		int b;
		int ending;
		bit d;
		logic [31:0] isn_a, isn_b, fin_a, fin_b;
		a = $urandom_range(0, 1023);
		b = ($urandom_range(0, 24) == 0) ? a : $urandom_range(0, 1023);
		isn_a = $urandom;
		isn_b = $urandom;
		fin_a = $urandom;
		fin_b = $urandom;
		n_conv++;
		send_event(OP_CLEAR, a, 1'($urandom_range(0, 1)), a, 8'($urandom_range(0, 255)),
			$urandom, $urandom);
		send_event(OP_CLEAR, b, 1'b0, $urandom_range(0, 1023), 8'($urandom_range(0, 255)),
			$urandom, $urandom);
		// Most conversations open with a three-way handshake; the rest start mid-stream.
		if ($urandom_range(0, 7) != 0) begin
			conv_seg(a, b, 1'b0, F_SYN, isn_a, $urandom);
			conv_seg(a, b, 1'b1, F_SYN | F_ACK, isn_b, isn_a + 32'd1);
			conv_seg(a, b, 1'b0, F_ACK, isn_a + 32'd1, isn_b + 32'd1);
		end
		repeat ($urandom_range(0, 4))
			conv_seg(a, b, 1'($urandom_range(0, 1)),
				F_ACK | ($urandom_range(0, 1) ? F_PSH : 8'h00), $urandom, $urandom);
		ending = $urandom_range(0, 5);
		d = 1'($urandom_range(0, 1));
		if (ending <= 2) begin
			conv_seg(a, b, d, F_FIN | F_ACK, fin_a, $urandom);
			conv_seg(a, b, !d, F_ACK, $urandom, fin_a + 32'd1);
			conv_seg(a, b, !d, F_FIN | F_ACK, fin_b, fin_a + 32'd1);
			conv_seg(a, b, d, F_ACK, fin_a + 32'd1, fin_b + 32'd1);
			if ($urandom_range(0, 3) == 0)
				conv_seg(a, b, 1'($urandom_range(0, 1)), F_ACK, $urandom, $urandom);
		end else if (ending == 3) begin
			conv_seg(a, b, d, $urandom_range(0, 1) ? F_RST : F_RST | F_ACK, $urandom, $urandom);
			if ($urandom_range(0, 1) == 0)
				conv_seg(a, b, 1'($urandom_range(0, 1)), F_ACK, $urandom, $urandom);
		end else if (ending == 4) begin
			conv_seg(a, b, d, F_FIN | F_ACK, fin_a, $urandom);
		end
		send_event(OP_TERM, a, 1'b1, b, 8'($urandom_range(0, 255)), $urandom, $urandom);
		send_event(OP_TERM, b, 1'($urandom_range(0, 1)), a, 8'($urandom_range(0, 255)),
			$urandom, $urandom);
	endtask

	task automatic send_noise();
		logic [1:0] op;
		int fi;
		int oi;
		bit hop;
		op = 2'($urandom_range(0, 3));
		hop = 1'($urandom_range(0, 1));
		if (live_flows.size() == 0) begin
			op = OP_CLEAR;
			hop = 1'b0;
		end
		fi = (op == OP_CLEAR) ? $urandom_range(0, 1023) : pick_live();
		if (live_flows.size() != 0 && (hop || $urandom_range(0, 1)))
			oi = pick_live();
		else
			oi = $urandom_range(0, 1023);
		send_event(op, fi, hop, oi, 8'($urandom_range(0, 255)), $urandom, $urandom);
	endtask

	task automatic test_directed();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		// Handshake and graceful close between the lowest and highest flow;
		// the SYN sequence number wraps on acknowledgement.
		send_event(OP_CLEAR, 0, 1'b0, 1023, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(OP_CLEAR, 1023, 1'b1, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 0, 1'b1, 1023, F_SYN, 32'hFFFF_FFFF, 32'h0);
		send_event(OP_SEG, 1023, 1'b1, 0, F_SYN | F_ACK, 32'h1234_5678, 32'h0);
		send_event(OP_SEG, 0, 1'b1, 1023, F_ACK, 32'h0, 32'h1234_5679);
		send_event(OP_SEG, 1023, 1'b1, 0, F_SYN, 32'h1, 32'h2);
		send_event(OP_SEG, 0, 1'b1, 1023, F_FIN | F_ACK, 32'h10, 32'h1234_5679);
		send_event(OP_SEG, 1023, 1'b1, 0, F_FIN | F_ACK, 32'h1234_5679, 32'h11);
		send_event(OP_SEG, 0, 1'b1, 1023, F_ACK, 32'h11, 32'h1234_567A);
		send_event(OP_SEG, 1023, 1'b1, 0, F_ACK, 32'h0, 32'h0);
		send_event(OP_SEG, 1023, 1'b1, 0, F_RST, 32'h0, 32'h0);
		send_event(OP_TERM, 0, 1'b1, 1023, 8'h00, 32'h0, 32'h0);
		send_event(OP_TERM, 1023, 1'b1, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_NOP, 0, 1'b1, 1023, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// A flow that is its own reverse flow.
		send_event(OP_CLEAR, 'h2AA, 1'b1, 'h2AA, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 'h2AA, 1'b1, 'h2AA, F_SYN, 32'h5555_5555, 32'h0);
		send_event(OP_SEG, 'h2AA, 1'b1, 'h2AA, F_ACK, 32'h5555_5556, 32'h5555_5556);
		send_event(OP_SEG, 'h2AA, 1'b1, 'h2AA, F_RST, 32'h0, 32'h0);
		// A lone flow: reset with no reverse flow, traffic after reset, termination.
		send_event(OP_CLEAR, 'h155, 1'b0, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 'h155, 1'b0, 0, F_RST, 32'hAAAA_AAAA, 32'h5555_5555);
		send_event(OP_SEG, 'h155, 1'b0, 0, F_ACK, 32'h0, 32'h0);
		send_event(OP_TERM, 'h155, 1'b0, 0, 8'h00, 32'h0, 32'h0);
		// Xmas scan, null scan, FIN scan, then RST|ACK from a cleared flow to the FIN-scanned one.
		send_event(OP_CLEAR, 'h0F0, 1'b0, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 'h0F0, 1'b0, 0, XMAS, 32'h0, 32'h0);
		send_event(OP_SEG, 'h0F0, 1'b0, 0, 8'hC0, 32'h0, 32'h0);
		send_event(OP_CLEAR, 'h30F, 1'b0, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 'h30F, 1'b0, 0, F_FIN | F_ACK, 32'h77, 32'h0);
		send_event(OP_TERM, 'h30F, 1'b0, 0, 8'h00, 32'h0, 32'h0);
		send_event(OP_CLEAR, 'h0F0, 1'b1, 'h30F, 8'h00, 32'h0, 32'h0);
		send_event(OP_SEG, 'h0F0, 1'b1, 'h30F, F_RST | F_ACK, 32'h0, 32'h0);
		send_event(OP_SEG, 'h30F, 1'b1, 'h0F0, F_FIN, 32'h0, 32'h0);
		settle();
	endtask

	task automatic test_config_extremes();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int k = REG_TO_RESET; k <= REG_TO_CLOSED; k++) write_reg(CFG_AW'(k), 16'h0000);
		repeat (4) run_conversation();
		settle();
		for (int k = REG_TO_RESET; k <= REG_TO_CLOSED; k++) write_reg(CFG_AW'(k), 16'hFFFF);
		repeat (4) run_conversation();
		settle();
		// Writes above the last register must leave the timeouts untouched.
		for (int k = REG_UNUSED; k <= REG_LAST; k++) write_reg(CFG_AW'(k), 16'($urandom));
		repeat (2) run_conversation();
		settle();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = 300;
		repeat (3) run_conversation();
		settle();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (20) send_noise();
		settle();
	endtask

	task automatic test_random_traffic();
		int target;
		int phase_end;
		target = n_sent + 1570;
		while (n_sent < target) begin
			phase_end = n_sent + 350;
			tx_idle = 1'($urandom_range(0, 1));
			rx_idle = 1'($urandom_range(0, 1));
			while (n_sent < phase_end && n_sent < target) begin
				if ($urandom_range(0, 3) != 0) run_conversation();
				else repeat ($urandom_range(1, 5)) send_noise();
			end
			settle();
			load_random_timeouts();
		end
	endtask

	// Receiver: after each word it may hold ready low for a drawn number of cycles,
	// or for a long stretch when a test asks for it.
	initial begin
		res_bus.ready <= 1'b0;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1 && rx_idle)
				rx_wait = $urandom_range(0, 10);
			if (rx_hold > 0) begin
				rx_hold--;
				res_bus.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		flow_report_t due;
		if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$error("result word arrived with no event outstanding");
				n_fail++;
			end else begin
				due = expected_reports.pop_front();
				check_field("anomalies", 16'(due.anomalies), 16'(res_bus.anomalies));
				check_field("flow_state", 16'(due.flow_state), 16'(res_bus.flow_state));
				check_field("flow_timeout_valid", 16'(due.flow_timeout_valid),
					16'(res_bus.flow_timeout_valid));
				check_field("flow_timeout_value", due.flow_timeout_value,
					res_bus.flow_timeout_value);
				check_field("opp_timeout_valid", 16'(due.opp_timeout_valid),
					16'(res_bus.opp_timeout_valid));
				check_field("opp_timeout_value", due.opp_timeout_value,
					res_bus.opp_timeout_value);
				check_field("aggregate_anomalies", 16'(due.aggregate_anomalies),
					16'(res_bus.aggregate_anomalies));
				n_checked++;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		evt_bus.valid <= 1'b0;
		evt_bus.opcode <= OP_CLEAR;
		evt_bus.flow_index <= '0;
		evt_bus.has_opposite <= 1'b0;
		evt_bus.opposite_index <= '0;
		evt_bus.tcp_flags <= '0;
		evt_bus.seq_num <= '0;
		evt_bus.ack_num <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.addr <= REG_TO_RESET;
		cfg_bus.data <= '0;
		foreach (flow_tab[i]) flow_tab[i] = '0;
		agg_or = A_NONE;
		tmo.t_reset = 16'd1;
		tmo.t_new = 16'd120;
		tmo.t_est = 16'd3600;
		tmo.t_closing = 16'd120;
		tmo.t_closed = 16'd10;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();

		settle();
		repeat (20) @(posedge clk);
		$display("Ran %0d events (%0d flow conversations plus directed and stray words),",
			n_sent, n_conv);
		$display("checked %0d result words across %0d register writes.", n_checked, n_cfg);
		if (n_fail == 0 && expected_reports.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
